[rtl/itdt_pkg.sv]
package itdt_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CharW     = 6;
  localparam int unsigned OutBytesW = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DigitMax  = 10;
  localparam int unsigned DigitIdxW = $clog2(DigitMax);
  localparam int unsigned CntW      = $clog2(DigitMax + 1);

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  // ceil(2^35 / 10): floor(x * DivMagic / 2^35) == x / 10 for every 32-bit x
  localparam logic [DataW-1:0] DivMagic = 32'hCCCC_CCCD;
  localparam int unsigned      DivShift = 35;

endpackage

[rtl/itdt_div10.sv]
module itdt_div10 (
  input  logic [itdt_pkg::DataW-1:0]  mag,
  output logic [itdt_pkg::DataW-1:0]  quot,
  output logic [itdt_pkg::DigitW-1:0] rem
);

  logic [2*itdt_pkg::DataW-1:0] prod;
  logic [itdt_pkg::DigitW-1:0]  qlo;
  logic [itdt_pkg::DigitW-1:0]  q10lo;

  assign prod  = (2*itdt_pkg::DataW)'(mag) * (2*itdt_pkg::DataW)'(itdt_pkg::DivMagic);
  assign quot  = itdt_pkg::DataW'(prod >> itdt_pkg::DivShift);
  assign qlo   = quot[itdt_pkg::DigitW-1:0];
  // remainder < 10, so the low four bits of mag - 10*q are exact
  assign q10lo = (qlo << 3) + (qlo << 1);
  assign rem   = mag[itdt_pkg::DigitW-1:0] - q10lo;

endmodule

[rtl/integer_to_decimal_text.sv]
// Converts one signed 32-bit integer into its decimal ASCII text, sent one
// character per output item, most significant first: '-' for negative values,
// then the digits without leading zeros ("0" for zero, "-2147483648" for the
// most negative value). tlast marks the final character. A single
// divide-by-ten unit (reciprocal multiply) produces one digit per cycle, least
// significant first, into a ten-entry digit buffer; the text is then read back
// out of that buffer. An item with N digits (N = 1..10) is accepted, its
// digits are produced, and N characters, plus one for a sign, are then sent,
// one per transfer taken by the sink. No new item is accepted until the last
// character of the current one has been taken.
module integer_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] text_char, [7:6] zero
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t                             state;
  logic                               neg;
  logic [itdt_pkg::DataW-1:0]         mag;
  logic [itdt_pkg::DigitIdxW-1:0]     ndig;
  logic [itdt_pkg::CntW-1:0]          ptr;
  logic [itdt_pkg::DigitW-1:0]        digits [itdt_pkg::DigitMax];
  logic [itdt_pkg::CharW-1:0]         text_char;

  logic [itdt_pkg::DataW-1:0]         quot;
  logic [itdt_pkg::DigitW-1:0]        rem;
  logic                               div_done;
  logic [itdt_pkg::DigitW-1:0]        rd_digit;
  logic [itdt_pkg::CntW-1:0]          ptr_dec;

  itdt_div10 u_div10 (
    .mag  (mag),
    .quot (quot),
    .rem  (rem)
  );

  assign div_done = (quot == '0) ||
                    (ndig == itdt_pkg::DigitIdxW'(itdt_pkg::DigitMax - 1));
  assign ptr_dec  = ptr - itdt_pkg::CntW'(1);
  assign rd_digit = digits[ptr_dec[itdt_pkg::DigitIdxW-1:0]];

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {2'b00, text_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            neg   <= s_axis_tdata[31];
            mag   <= s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
            ndig  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          digits[ndig] <= rem;
          mag          <= quot;
          ndig         <= ndig + itdt_pkg::DigitIdxW'(1);
          if (div_done) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_EMIT;
            if (neg) begin
              text_char    <= itdt_pkg::CharMinus;
              m_axis_tlast <= 1'b0;
              ptr          <= itdt_pkg::CntW'(ndig) + itdt_pkg::CntW'(1);
            end else begin
              text_char    <= itdt_pkg::CharZero + itdt_pkg::CharW'(rem);
              m_axis_tlast <= (ndig == '0);
              ptr          <= itdt_pkg::CntW'(ndig);
            end
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            if (ptr == '0) begin
              m_axis_tvalid <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              text_char    <= itdt_pkg::CharZero + itdt_pkg::CharW'(rd_digit);
              m_axis_tlast <= (ptr == itdt_pkg::CntW'(1));
              ptr          <= ptr_dec;
            end
          end
        end
        default: begin
          state         <= ST_IDLE;
          m_axis_tvalid <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[5:0] == itdt_pkg::CharMinus) |-> !m_axis_tlast)
    else $error("sign marked last");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[5:0] >= itdt_pkg::CharZero))
    else $error("last character not a digit");
`endif

endmodule

[test/testbench.sv]
module testbench;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

  class text_scoreboard;
    logic [itdt_pkg::CharW-1:0] exp_char[$];
    bit                         exp_last[$];
    int                         errors = 0;

    // Expected characters of one accepted value, most significant first
    function void note_value(logic [itdt_pkg::DataW-1:0] value);
      logic [itdt_pkg::DataW-1:0]  mag;
      logic [itdt_pkg::DigitW-1:0] digits[itdt_pkg::DigitMax];
      int                          n;
      mag = value[itdt_pkg::DataW-1] ? (~value + 1'b1) : value;
      n = 0;
      do begin
        digits[n] = itdt_pkg::DigitW'(mag % 10);
        mag = mag / 10;
        n++;
      end while (mag != 0 && n < itdt_pkg::DigitMax);
      if (value[itdt_pkg::DataW-1]) begin
        exp_char.push_back(itdt_pkg::CharMinus);
        exp_last.push_back(1'b0);
      end
      for (int k = n - 1; k >= 0; k--) begin
        exp_char.push_back(itdt_pkg::CharZero + itdt_pkg::CharW'(digits[k]));
        exp_last.push_back(k == 0);
      end
    endfunction

    function void check_char(logic [7:0] data, logic last);
      logic [itdt_pkg::CharW-1:0] want_char;
      bit                         want_last;
      if (exp_char.size() == 0) begin
        $error("unexpected item: text_char=%0d last=%0d",
               data[itdt_pkg::CharW-1:0], last);
        errors++;
        return;
      end
      want_char = exp_char.pop_front();
      want_last = exp_last.pop_front();
      if (data[itdt_pkg::CharW-1:0] !== want_char) begin
        $error("text_char: expected %0d, got %0d", want_char,
               data[itdt_pkg::CharW-1:0]);
        errors++;
      end
      if (last !== want_last) begin
        $error("last: expected %0d, got %0d", want_last, last);
        errors++;
      end
      if (data[7:itdt_pkg::CharW] !== '0) begin
        $error("tdata pad: expected 0, got %0d", data[7:itdt_pkg::CharW]);
        errors++;
      end
    endfunction

    function int pending();
      return exp_char.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  text_scoreboard text_sb;
  idle_mode_t     mode = IdleNone;
  bit             hold_request = 1'b0;

  integer_to_decimal_text dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int sender_pct(idle_mode_t m);
    case (m)
      IdleSender: return 85;
      IdleBoth:   return 12;
      default:    return 0;
    endcase
  endfunction

  function automatic int receiver_pct(idle_mode_t m);
    case (m)
      IdleReceiver: return 85;
      IdleBoth:     return 12;
      default:      return 0;
    endcase
  endfunction

  // Random digit count first so short and long numbers are equally common; one value in five is a raw random word
  function automatic logic [31:0] random_value();
    int unsigned         len;
    longint              lo;
    longint              hi;
    longint              v;
    longint unsigned     r;
    if ($urandom_range(0, 4) == 0) return $urandom;
    len = $urandom_range(1, 10);
    lo = 1;
    repeat (len - 1) lo *= 10;
    hi = lo * 10 - 1;
    if (len == 1) lo = 0;
    if (hi > 64'sd2147483648) hi = 64'sd2147483648;
    r = {$urandom, $urandom};
    v = lo + longint'(r % longint'(hi - lo + 1));
    if ($urandom_range(0, 1)) v = -v;
    else if (v > 64'sd2147483647) v = 64'sd2147483647;
    return v[31:0];
  endfunction

  task automatic send_value(logic [31:0] value);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(0, 99) < sender_pct(mode)) gap++;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk); while (!s_axis_tready);
    text_sb.note_value(value);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (text_sb.pending() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= receiver_pct(mode));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      text_sb.check_char(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #(8 * 400000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0]  directed[$];
    idle_mode_t   phases[4];
    text_sb = new();
    directed = '{32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, 32'd99, 32'd100,
                 32'd12345, -32'd12345, 32'd999999999, 32'd1000000000,
                 -32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890,
                 -32'd999, 32'd42};
    phases = '{IdleNone, IdleSender, IdleReceiver, IdleBoth};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_value(directed[i]);

    // Long receiver hold-off while input keeps coming: input must back up
    hold_request = 1'b1;
    repeat (12) send_value(random_value());
    wait_drained();

    foreach (phases[p]) begin
      mode = phases[p];
      repeat (80) send_value(random_value());
      wait_drained();
    end
    mode = IdleNone;
    repeat (30) @(negedge clk);

    if (text_sb.errors == 0 && text_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
